// ===== rtl/srpg_pkg.sv =====
// Package: shared types, codes and constants of the stepper ramp pulse generator.
package srpg_pkg;

   localparam int FRAC_BITS = 8;
   localparam int PERIOD_W = 32;
   localparam int WHOLE_W = 24;
   localparam int COUNT_W = 32;
   localparam int RAMP_W = 33;
   localparam int DIVIDEND_W = PERIOD_W + 1;
   localparam int DIVISOR_W = 34;
   localparam int DIV_STEPS = DIVIDEND_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [WHOLE_W-1:0] WHOLE_MAX = {WHOLE_W{1'b1}};
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;

   localparam logic [1:0] IDX_START_PERIOD = 2'd0;
   localparam logic [1:0] IDX_MIN_PERIOD = 2'd1;
   localparam logic [1:0] IDX_DECEL_LIMIT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_FIX,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic div_step;
      logic fix;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_status_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] start_period;
      logic [PERIOD_W-1:0] min_period;
      logic [COUNT_W-1:0] decel_limit;
   } cfg_type;

endpackage

// ===== rtl/stepper_ramp_pulse_generator.sv =====
// Top level of the stepper ramp pulse generator.
//
// Usage: each req_ item is a command: a one-microsecond tick, a start of a
// move (direction and step count) or a stop with deceleration. Every item
// yields exactly one rsp_ item with the step pulse flag, direction level,
// busy flag, steps issued so far and the current whole period.
// An item is taken when req_valid is high and req_stall low; a result is
// taken when rsp_valid is high and rsp_stall low.
// Items that do not compute a new ramp period pass through the execute
// and output states; a tick that fires a step after the first one also
// runs the 33-iteration restoring divider that forms 2p / (4n + 1) one
// quotient bit per cycle, then the fix state. One item is in work at a
// time; the next is accepted only after the previous result is loaded
// into the output register.
// A result held under rsp_stall stays in the output register while the
// next item is accepted and worked; that item's result waits for the
// register to free.
// Reset (synchronous, active high) clears the move state and loads the
// configuration defaults. Configuration registers sit at byte addresses
// 0, 4 and 8; the user must see that they are written only while the block is idle, as the block does not enforce it.
module stepper_ramp_pulse_generator
   import srpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic                  req_direction,
   input  logic [COUNT_W-1:0]    req_step_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_step_pulse,
   output logic                  rsp_dir_level,
   output logic                  rsp_busy_res,
   output logic [COUNT_W-1:0]    rsp_steps_done,
   output logic [WHOLE_W-1:0]    rsp_period_now,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   srpg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   srpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srpg_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .cfg            (cfg),
      .req_command    (req_command),
      .req_direction  (req_direction),
      .req_step_count (req_step_count),
      .rsp_step_pulse (rsp_step_pulse),
      .rsp_dir_level  (rsp_dir_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_steps_done (rsp_steps_done),
      .rsp_period_now (rsp_period_now)
   );

endmodule

// ===== rtl/srpg_csr.sv =====
// Configuration registers behind the APB-style port.
module srpg_csr
   import srpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [PERIOD_W-1:0] start_period_ff, start_period_in;
   logic [PERIOD_W-1:0] min_period_ff, min_period_in;
   logic [COUNT_W-1:0]  decel_limit_ff, decel_limit_in;
   logic                wr_en;
   logic [1:0]          idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      start_period_in = start_period_ff;
      min_period_in = min_period_ff;
      decel_limit_in = decel_limit_ff;
      if (wr_en) begin
         unique case (idx)
            IDX_START_PERIOD: start_period_in = csr_pwdata;
            IDX_MIN_PERIOD:   min_period_in = csr_pwdata;
            IDX_DECEL_LIMIT:  decel_limit_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         IDX_START_PERIOD: csr_prdata = start_period_ff;
         IDX_MIN_PERIOD:   csr_prdata = min_period_ff;
         IDX_DECEL_LIMIT:  csr_prdata = decel_limit_ff;
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_period_ff <= 32'd256000;
         min_period_ff <= 32'd25600;
         decel_limit_ff <= 32'd1000;
      end else begin
         start_period_ff <= start_period_in;
         min_period_ff <= min_period_in;
         decel_limit_ff <= decel_limit_in;
      end
   end

   assign cfg.start_period = start_period_ff;
   assign cfg.min_period = min_period_ff;
   assign cfg.decel_limit = decel_limit_ff;

endmodule

// ===== rtl/srpg_ctrl.sv =====
// Controller: sequences item execution, the divider iterations and result hand-off.
module srpg_ctrl
   import srpg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 slot_free;

   assign slot_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.need_div ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            if (cnt_ff == DIV_LAST) state_in = ST_FIX;
         end
         ST_FIX: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.latch = req_valid;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_FIX:  cmd.fix = 1'b1;
         ST_OUT:  cmd.load_out = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = (state_ff == ST_DIV) ? cnt_ff + 1'b1 : '0;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (cmd.load_out) out_valid_in = 1'b1;
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/srpg_dp.sv =====
// Datapath: move state, step timing, iterative period divider and result register.
module srpg_dp
   import srpg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  cfg_type             cfg,
   input  logic [1:0]          req_command,
   input  logic                req_direction,
   input  logic [COUNT_W-1:0]  req_step_count,
   output logic                rsp_step_pulse,
   output logic                rsp_dir_level,
   output logic                rsp_busy_res,
   output logic [COUNT_W-1:0]  rsp_steps_done,
   output logic [WHOLE_W-1:0]  rsp_period_now
);

   function automatic logic [WHOLE_W-1:0] whole_of(input logic [PERIOD_W-1:0] p);
      logic [PERIOD_W-1:0] s;
      s = p >> FRAC_BITS;
      return (s > PERIOD_W'(WHOLE_MAX)) ? WHOLE_MAX : s[WHOLE_W-1:0];
   endfunction

   // latched item
   logic [1:0]          lat_cmd_ff, lat_cmd_in;
   logic                lat_dir_ff, lat_dir_in;
   logic [COUNT_W-1:0]  lat_cnt_ff, lat_cnt_in;

   // move state
   logic [COUNT_W-1:0]  steps_left_ff, steps_left_in;
   logic [COUNT_W-1:0]  steps_issued_ff, steps_issued_in;
   logic [RAMP_W-1:0]   ramp_ff, ramp_in;
   logic [COUNT_W-1:0]  decel_ff, decel_in;
   logic [PERIOD_W-1:0] period_fixed_ff, period_fixed_in;
   logic [WHOLE_W-1:0]  period_whole_ff, period_whole_in;
   logic [WHOLE_W-1:0]  elapsed_ff, elapsed_in;
   logic                dir_ff, dir_in;
   logic                pulse_ff, pulse_in;

   // divider
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic                  neg_ff, neg_in;

   // result register
   logic                out_pulse_ff, out_pulse_in;
   logic                out_dir_ff, out_dir_in;
   logic                out_busy_ff, out_busy_in;
   logic [COUNT_W-1:0]  out_done_ff, out_done_in;
   logic [WHOLE_W-1:0]  out_period_ff, out_period_in;

   logic [WHOLE_W-1:0]  el_inc;
   logic                fire;
   logic [RAMP_W-1:0]   ramp_adj;
   logic [RAMP_W-1:0]   ramp_mag;
   logic [DIVISOR_W-1:0] den_mag;
   logic [DIVISOR_W:0]  r_sh;
   logic                ge;
   logic signed [PERIOD_W+2:0] np;
   logic [COUNT_W-1:0]  half;
   logic [COUNT_W-1:0]  stop_decel;

   assign el_inc = (elapsed_ff < WHOLE_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign fire = (lat_cmd_ff == CMD_TICK) && (steps_left_ff != '0) &&
                 (el_inc >= period_whole_ff);
   assign status.need_div = fire && (steps_issued_ff != '0);

   assign ramp_adj = (!ramp_ff[RAMP_W-1] && (ramp_ff != '0) && (decel_ff >= steps_left_ff))
                     ? RAMP_W'(-{1'b0, decel_ff}) : ramp_ff;
   assign ramp_mag = ramp_adj[RAMP_W-1] ? RAMP_W'(-ramp_adj) : ramp_adj;
   assign den_mag = ramp_adj[RAMP_W-1] ? {ramp_mag[COUNT_W-1:0], 2'b00} - 1'b1
                                       : {ramp_mag[COUNT_W-1:0], 2'b01};

   assign r_sh = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign ge = r_sh >= {1'b0, dvs_ff};

   assign np = neg_ff ? $signed({3'b000, period_fixed_ff}) + $signed({2'b00, quo_ff})
                      : $signed({3'b000, period_fixed_ff}) - $signed({2'b00, quo_ff});

   assign half = lat_cnt_ff >> 1;
   assign stop_decel = (steps_issued_ff < decel_ff) ? steps_issued_ff : decel_ff;

   always_comb begin
      lat_cmd_in = lat_cmd_ff;
      lat_dir_in = lat_dir_ff;
      lat_cnt_in = lat_cnt_ff;
      steps_left_in = steps_left_ff;
      steps_issued_in = steps_issued_ff;
      ramp_in = ramp_ff;
      decel_in = decel_ff;
      period_fixed_in = period_fixed_ff;
      period_whole_in = period_whole_ff;
      elapsed_in = elapsed_ff;
      dir_in = dir_ff;
      pulse_in = pulse_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      out_pulse_in = out_pulse_ff;
      out_dir_in = out_dir_ff;
      out_busy_in = out_busy_ff;
      out_done_in = out_done_ff;
      out_period_in = out_period_ff;

      if (cmd.latch) begin
         lat_cmd_in = req_command;
         lat_dir_in = req_direction;
         lat_cnt_in = req_step_count;
      end

      if (cmd.exec) begin
         pulse_in = fire;
         case (lat_cmd_ff)
            CMD_TICK: begin
               if (steps_left_ff != '0) begin
                  elapsed_in = el_inc;
                  if (status.need_div) begin
                     ramp_in = ramp_adj;
                     neg_in = ramp_adj[RAMP_W-1];
                     dvd_in = {period_fixed_ff, 1'b0};
                     dvs_in = den_mag;
                     rem_in = '0;
                     quo_in = '0;
                  end else if (fire) begin
                     period_fixed_in = cfg.start_period;
                     period_whole_in = whole_of(cfg.start_period);
                     steps_left_in = steps_left_ff - 1'b1;
                     steps_issued_in = steps_issued_ff + 1'b1;
                     ramp_in = ramp_ff + 1'b1;
                     elapsed_in = '0;
                  end
               end
            end
            CMD_START: begin
               steps_left_in = lat_cnt_ff;
               steps_issued_in = '0;
               ramp_in = '0;
               elapsed_in = '0;
               period_whole_in = '0;
               decel_in = (cfg.decel_limit < half) ? cfg.decel_limit : half;
               dir_in = lat_dir_ff;
            end
            CMD_STOP: begin
               if (steps_left_ff != '0) begin
                  decel_in = stop_decel;
                  steps_left_in = stop_decel + 1'b1;
                  ramp_in = RAMP_W'(-({1'b0, stop_decel} + 1'b1));
               end
            end
            default: ;
         endcase
      end

      if (cmd.div_step) begin
         rem_in = ge ? DIVISOR_W'(r_sh - {1'b0, dvs_ff}) : r_sh[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
      end

      if (cmd.fix) begin
         if (np < $signed({3'b000, cfg.min_period})) begin
            period_fixed_in = cfg.min_period;
         end else if (np[PERIOD_W+2:PERIOD_W] != 3'b000) begin
            period_fixed_in = {PERIOD_W{1'b1}};
         end else begin
            period_fixed_in = np[PERIOD_W-1:0];
         end
         period_whole_in = whole_of(period_fixed_in);
         steps_left_in = steps_left_ff - 1'b1;
         steps_issued_in = steps_issued_ff + 1'b1;
         ramp_in = ramp_ff + 1'b1;
         elapsed_in = '0;
      end

      if (cmd.load_out) begin
         out_pulse_in = pulse_ff;
         out_dir_in = dir_ff;
         out_busy_in = steps_left_ff != '0;
         out_done_in = steps_issued_ff;
         out_period_in = period_whole_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_left_ff <= '0;
         steps_issued_ff <= '0;
         ramp_ff <= '0;
         decel_ff <= '0;
         period_fixed_ff <= '0;
         period_whole_ff <= '0;
         elapsed_ff <= '0;
         dir_ff <= 1'b0;
      end else begin
         steps_left_ff <= steps_left_in;
         steps_issued_ff <= steps_issued_in;
         ramp_ff <= ramp_in;
         decel_ff <= decel_in;
         period_fixed_ff <= period_fixed_in;
         period_whole_ff <= period_whole_in;
         elapsed_ff <= elapsed_in;
         dir_ff <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      lat_cmd_ff <= lat_cmd_in;
      lat_dir_ff <= lat_dir_in;
      lat_cnt_ff <= lat_cnt_in;
      pulse_ff <= pulse_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      out_pulse_ff <= out_pulse_in;
      out_dir_ff <= out_dir_in;
      out_busy_ff <= out_busy_in;
      out_done_ff <= out_done_in;
      out_period_ff <= out_period_in;
   end

   assign rsp_step_pulse = out_pulse_ff;
   assign rsp_dir_level = out_dir_ff;
   assign rsp_busy_res = out_busy_ff;
   assign rsp_steps_done = out_done_ff;
   assign rsp_period_now = out_period_ff;

endmodule

// ===== tb/stepper_ramp_pulse_generator_tb.sv =====
// Self-checking testbench for the stepper ramp pulse generator: random ramp moves, checked per item.
`timescale 1ns / 100ps

import srpg_pkg::*;

typedef struct packed {
   logic               pulse;
   logic               dir;
   logic               busy;
   logic [COUNT_W-1:0] done;
   logic [WHOLE_W-1:0] period;
} step_report_type;

class motion_ledger;
   bit [PERIOD_W-1:0] cfg_first;
   bit [PERIOD_W-1:0] cfg_floor;
   bit [COUNT_W-1:0]  cfg_decel;
   bit [COUNT_W-1:0]  remain;
   bit [COUNT_W-1:0]  issued;
   longint            ramp;
   bit [COUNT_W-1:0]  decel_len;
   bit [PERIOD_W-1:0] period_fx;
   bit [WHOLE_W-1:0]  period_us;
   bit [WHOLE_W-1:0]  since_step;
   bit                dir_now;
   step_report_type   due_reports[$];
   int                errors;

   function new();
      cfg_first = 32'd256000;
      cfg_floor = 32'd25600;
      cfg_decel = 32'd1000;
      remain = '0;
      issued = '0;
      ramp = 0;
      decel_len = '0;
      period_fx = '0;
      period_us = '0;
      since_step = '0;
      dir_now = 1'b0;
      errors = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         IDX_START_PERIOD: cfg_first = value;
         IDX_MIN_PERIOD: cfg_floor = value;
         IDX_DECEL_LIMIT: cfg_decel = value;
         default: ;
      endcase
   endfunction

   function bit moving();
      return remain != 0;
   endfunction

   function int pending();
      return due_reports.size();
   endfunction

   function void note_command(logic [1:0] cmd, logic dir, logic [COUNT_W-1:0] cnt);
      step_report_type rep;
      longint p;
      longint den;
      longint np;
      longint floor_l;
      longint cap;
      bit [PERIOD_W-1:0] w;
      bit [COUNT_W-1:0] half;
      rep.pulse = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (remain != 0) begin
               if (since_step < WHOLE_MAX)
                  since_step++;
               if (since_step >= period_us) begin
                  rep.pulse = 1'b1;
                  if (issued == 0) begin
                     period_fx = cfg_first;
                  end else begin
                     p = longint'({32'd0, period_fx});
                     floor_l = longint'({32'd0, cfg_floor});
                     cap = 64'h0000_0000_ffff_ffff;
                     if (ramp > 0 && decel_len >= remain)
                        ramp = -longint'({32'd0, decel_len});
                     den = 4 * ramp + 1;
                     np = p - (2 * p) / den;
                     if (np < floor_l)
                        np = floor_l;
                     if (np > cap)
                        np = cap;
                     period_fx = np[PERIOD_W-1:0];
                  end
                  w = period_fx >> FRAC_BITS;
                  period_us = (w > WHOLE_MAX) ? WHOLE_MAX : w[WHOLE_W-1:0];
                  remain--;
                  issued++;
                  ramp++;
                  since_step = '0;
               end
            end
         end
         CMD_START: begin
            half = cnt / 2;
            remain = cnt;
            issued = '0;
            ramp = 0;
            since_step = '0;
            period_us = '0;
            decel_len = (cfg_decel < half) ? cfg_decel : half;
            dir_now = dir;
         end
         CMD_STOP: begin
            if (remain != 0) begin
               if (issued < decel_len)
                  decel_len = issued;
               remain = decel_len + 1;
               ramp = -longint'({32'd0, remain});
            end
         end
         default: ;
      endcase
      rep.dir = dir_now;
      rep.busy = (remain != 0);
      rep.done = issued;
      rep.period = period_us;
      due_reports.push_back(rep);
   endfunction

   function void flag(string field, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
   endfunction

   function void check_report(step_report_type got);
      step_report_type want;
      if (due_reports.size() == 0) begin
         errors++;
         $display("%0t result item with none pending: expected nothing, actual %p",
                  $time, got);
         return;
      end
      want = due_reports.pop_front();
      if (got.pulse !== want.pulse)
         flag("step_pulse", want.pulse, got.pulse);
      if (got.dir !== want.dir)
         flag("dir_level", want.dir, got.dir);
      if (got.busy !== want.busy)
         flag("busy_res", want.busy, got.busy);
      if (got.done !== want.done)
         flag("steps_done", want.done, got.done);
      if (got.period !== want.period)
         flag("period_now", want.period, got.period);
   endfunction
endclass

module stepper_ramp_pulse_generator_tb;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 48;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_command = CMD_TICK;
   logic                  req_direction = 1'b0;
   logic [COUNT_W-1:0]    req_step_count = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_step_pulse;
   logic                  rsp_dir_level;
   logic                  rsp_busy_res;
   logic [COUNT_W-1:0]    rsp_steps_done;
   logic [WHOLE_W-1:0]    rsp_period_now;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   motion_ledger ledger = new;
   int quiet_send = 0;
   int quiet_recv = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   stepper_ramp_pulse_generator dut (.*);

   always #6 clock = ~clock;

   function automatic int pick_gap(inout int quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if (roll < 2) begin
         quiet = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            ledger.check_report({rsp_step_pulse, rsp_dir_level, rsp_busy_res,
                                 rsp_steps_done, rsp_period_now});
         if (stall_left == 0)
            stall_left = pick_gap(quiet_recv);
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0)
            stall_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("stepper_ramp_pulse_generator: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [1:0] cmd, input logic dir,
                            input logic [COUNT_W-1:0] cnt);
      int gap;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_direction <= dir;
      req_step_count <= cnt;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      ledger.note_command(cmd, dir, cnt);
      gap = pick_gap(quiet_send);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      ledger.write_reg(idx, value);
   endtask

   task automatic set_profile(input logic [PERIOD_W-1:0] first, input logic [PERIOD_W-1:0] floor,
                              input logic [COUNT_W-1:0] decel);
      wait_quiet();
      csr_write(IDX_START_PERIOD, first);
      csr_write(IDX_MIN_PERIOD, floor);
      csr_write(IDX_DECEL_LIMIT, decel);
   endtask

   task automatic run_moves(input int count);
      int done_items;
      int roll;
      logic [1:0] cmd;
      logic [COUNT_W-1:0] cnt;
      done_items = 0;
      while (done_items < count) begin
         roll = $urandom_range(0, 99);
         cnt = $urandom;
         if (!ledger.moving()) begin
            if (roll < 78) begin
               cmd = CMD_START;
               if (roll < 66)
                  cnt = $urandom_range(1, 24);
               else if (roll < 72)
                  cnt = $urandom_range(0, 2);
            end else if (roll < 88) begin
               cmd = CMD_TICK;
            end else if (roll < 95) begin
               cmd = CMD_STOP;
            end else begin
               cmd = CMD_UNUSED;
            end
         end else begin
            if (roll < 86) begin
               cmd = CMD_TICK;
            end else if (roll < 92) begin
               cmd = CMD_STOP;
            end else if (roll < 97) begin
               cmd = CMD_START;
               if (roll < 96)
                  cnt = $urandom_range(1, 24);
            end else begin
               cmd = CMD_UNUSED;
            end
         end
         if (cmd == CMD_START || (ledger.moving() && cmd != CMD_UNUSED))
            done_items++;
         send_item(cmd, 1'($urandom_range(0, 1)), cnt);
      end
   endtask

   initial begin
      int phase;
      logic [PERIOD_W-1:0] first;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(CMD_TICK, 1'b1, '1);
      send_item(CMD_STOP, 1'b0, '0);
      send_item(CMD_UNUSED, 1'b1, '1);
      send_item(CMD_START, 1'b1, '0);
      send_item(CMD_START, 1'b1, 32'd3);
      send_item(CMD_TICK, 1'b0, '0);
      send_item(CMD_TICK, 1'b0, '0);
      send_item(CMD_STOP, 1'b0, '0);
      send_item(CMD_UNUSED, 1'b0, '0);
      send_item(CMD_START, 1'b0, '1);
      send_item(CMD_TICK, 1'b0, '0);

      set_profile('0, '0, '0);
      send_item(CMD_START, 1'b1, 32'd6);
      repeat (4) send_item(CMD_TICK, 1'b1, '1);
      send_item(CMD_STOP, 1'b0, '1);
      repeat (3) send_item(CMD_TICK, 1'b0, '0);

      set_profile('1, '1, '1);
      send_item(CMD_START, 1'b0, '1);
      repeat (2) send_item(CMD_TICK, 1'b0, '0);
      send_item(CMD_STOP, 1'b1, '0);
      send_item(CMD_TICK, 1'b0, '0);

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_profile(32'd1024, 32'd256, 32'd5);
            1: set_profile(32'h100, '1, 32'd3);
            2: set_profile(32'd2000, '0, '1);
            3: set_profile(32'd300, 32'd300, 32'd0);
            default: begin
               first = $urandom_range(0, 2560);
               set_profile(first, $urandom_range(0, first), $urandom_range(0, 30));
            end
         endcase
         run_moves(245);
      end

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0)
         $display("stepper_ramp_pulse_generator: match");
      else
         $display("stepper_ramp_pulse_generator: mismatch");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/srpg_pkg.sv
rtl/srpg_csr.sv
rtl/srpg_ctrl.sv
rtl/srpg_dp.sv
rtl/stepper_ramp_pulse_generator.sv
tb/stepper_ramp_pulse_generator_tb.sv
